[src/jsu_pkg.sv]
// shared types for the json string unescaper
// result group passed from the decoder to the output serializer
// no dependencies
`default_nettype none
package jsu_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned MaxOut = 3;

    typedef logic [ByteW-1:0] byte_t;

    typedef struct packed {
        logic [1:0]                cnt;
        logic [MaxOut-1:0][ByteW-1:0] data;
        logic                      eos;
    } group_t;

endpackage
`default_nettype wire

[src/jsu_decode.sv]
// escape decoder: decode state registers and single-step decode logic
// turns one source byte into a group of up to three result bytes
// depends on jsu_pkg
`default_nettype none
module jsu_decode (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire jsu_pkg::byte_t  in_byte,
    input  wire logic            eos,
    output jsu_pkg::group_t      grp
);

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_UHEX  = 2'd2
    } mode_t;

    localparam jsu_pkg::byte_t ChBslash = 8'h5c;
    localparam jsu_pkg::byte_t ChQuote  = 8'h22;
    localparam jsu_pkg::byte_t ChB      = 8'h62;
    localparam jsu_pkg::byte_t ChF      = 8'h66;
    localparam jsu_pkg::byte_t ChN      = 8'h6e;
    localparam jsu_pkg::byte_t ChR      = 8'h72;
    localparam jsu_pkg::byte_t ChT      = 8'h74;
    localparam jsu_pkg::byte_t ChU      = 8'h75;

    function automatic jsu_pkg::group_t utf8_enc(input logic [15:0] u);
        jsu_pkg::group_t g;
        g = '0;
        if (u < 16'h0080) begin
            g.cnt = 2'd1;
            g.data[0] = u[7:0];
        end else if (u < 16'h0800) begin
            g.cnt = 2'd2;
            g.data[0] = {3'b110, u[10:6]};
            g.data[1] = {2'b10, u[5:0]};
        end else begin
            g.cnt = 2'd3;
            g.data[0] = {4'b1110, u[15:12]};
            g.data[1] = {2'b10, u[11:6]};
            g.data[2] = {2'b10, u[5:0]};
        end
        return g;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [1:0]  seen_reg, seen_next;
    logic [15:0] code_reg, code_next;
    logic        stop_reg, stop_next;

    logic        is_hex;
    logic [3:0]  hex_val;
    logic [15:0] code_upd;

    always_comb begin
        is_hex  = 1'b0;
        hex_val = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            is_hex = 1'b1;
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            is_hex  = 1'b1;
            hex_val = in_byte[3:0] + 4'd9;
        end
    end

    assign code_upd = (!stop_reg && is_hex) ? {code_reg[11:0], hex_val} : code_reg;

    always_comb begin
        mode_next = mode_reg;
        seen_next = seen_reg;
        code_next = code_reg;
        stop_next = stop_reg;
        grp       = '0;
        unique case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_PLAIN;
                grp.cnt   = 2'd1;
                case (in_byte)
                    ChBslash: grp.data[0] = ChBslash;
                    ChQuote:  grp.data[0] = ChQuote;
                    ChB:      grp.data[0] = 8'h08;
                    ChF:      grp.data[0] = 8'h0c;
                    ChN:      grp.data[0] = 8'h0a;
                    ChR:      grp.data[0] = 8'h0d;
                    ChT:      grp.data[0] = 8'h09;
                    ChU: begin
                        mode_next = MODE_UHEX;
                        seen_next = 2'd0;
                        code_next = 16'h0000;
                        stop_next = 1'b0;
                        grp.cnt   = eos ? 2'd1 : 2'd0;
                    end
                    default: begin
                        grp.cnt     = 2'd2;
                        grp.data[0] = ChBslash;
                        grp.data[1] = in_byte;
                    end
                endcase
            end
            MODE_UHEX: begin
                stop_next = stop_reg | ~is_hex;
                code_next = code_upd;
                if (seen_reg == 2'd3 || eos) begin
                    grp       = utf8_enc(code_upd);
                    mode_next = MODE_PLAIN;
                    seen_next = 2'd0;
                    code_next = 16'h0000;
                    stop_next = 1'b0;
                end else begin
                    seen_next = seen_reg + 2'd1;
                end
            end
            default: begin
                if (in_byte == ChBslash) begin
                    if (eos) begin
                        grp.cnt     = 2'd1;
                        grp.data[0] = ChBslash;
                    end else begin
                        mode_next = MODE_ESC;
                    end
                end else begin
                    mode_next   = MODE_PLAIN;
                    grp.cnt     = 2'd1;
                    grp.data[0] = in_byte;
                end
            end
        endcase
        grp.eos = eos;
        if (eos) begin
            mode_next = MODE_PLAIN;
            seen_next = 2'd0;
            code_next = 16'h0000;
            stop_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
            seen_reg <= 2'd0;
            code_reg <= 16'h0000;
            stop_reg <= 1'b0;
        end else if (en) begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
            code_reg <= code_next;
            stop_reg <= stop_next;
        end
    end

endmodule
`default_nettype wire

[src/jsu_emit.sv]
// result register and serializer: holds one result group and sends its bytes
// one per request on the output channel
// depends on jsu_pkg
`default_nettype none
module jsu_emit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire jsu_pkg::group_t grp,
    output logic                 free,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output jsu_pkg::byte_t       m_out_byte,
    output logic                 m_run_last,
    output logic                 m_string_done
);

    jsu_pkg::group_t grp_reg;
    logic            vld_reg;
    logic [1:0]      idx_reg;
    logic            pop;
    logic            fin;

    assign m_valid = vld_reg;
    assign pop     = vld_reg && m_ready;
    assign m_run_last    = (idx_reg == grp_reg.cnt - 2'd1);
    assign m_string_done = m_run_last && grp_reg.eos;
    assign fin     = pop && m_run_last;
    assign free    = !vld_reg || fin;

    always_comb begin
        case (idx_reg)
            2'd0:    m_out_byte = grp_reg.data[0];
            2'd1:    m_out_byte = grp_reg.data[1];
            default: m_out_byte = grp_reg.data[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= 2'd0;
        end else if (load) begin
            vld_reg <= (grp.cnt != 2'd0);
            idx_reg <= 2'd0;
        end else if (fin) begin
            vld_reg <= 1'b0;
        end else if (pop) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp;
        end
    end

endmodule
`default_nettype wire

[src/json_string_unescape_utf8_top.sv]
// top level of the json string unescaper with utf-8 output
// input register, escape decoder and result serializer
// depends on jsu_pkg, jsu_decode, jsu_emit
`default_nettype none
// One source byte per request on s_, one unescaped byte per request on m_.
// A request is held in an input register, decoded combinationally into a group
// of zero to three result bytes that is loaded into the result register, and
// the group is sent from there one byte per cycle while m_ready is high.
// Throughput is one input byte per cycle while each byte yields at most one
// result and m_ready is high; a byte yielding n results (an unknown escape
// gives two, a \u escape up to three) holds the result register until all n
// are sent. Bytes that yield nothing (a backslash, the u and the first three
// hex digits of a \u escape) do not occupy the result register. m_run_last
// marks the last result of an input byte, m_string_done the last result of a
// string; every byte flagged end_of_string yields a result and returns the decoder to its reset state.
module json_string_unescape_utf8_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire jsu_pkg::byte_t s_in_byte,
    input  wire logic           s_end_of_string,
    output logic                m_valid,
    input  wire logic           m_ready,
    output jsu_pkg::byte_t      m_out_byte,
    output logic                m_run_last,
    output logic                m_string_done
);

    logic            in_vld_reg;
    jsu_pkg::byte_t  in_byte_reg;
    logic            in_eos_reg;
    logic            free;
    logic            load;
    jsu_pkg::group_t grp;

    assign load    = in_vld_reg && free;
    assign s_ready = !in_vld_reg || free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_eos_reg  <= s_end_of_string;
        end
    end

    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (load),
        .in_byte (in_byte_reg),
        .eos     (in_eos_reg),
        .grp     (grp)
    );

    jsu_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .grp           (grp),
        .free          (free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_string_done (m_string_done)
    );

endmodule
`default_nettype wire

[verif/json_string_unescape_utf8_checker.sv]
`timescale 1ns / 1ps
// checker for the json string unescaper: predicts the unescaped utf-8 bytes
// of every accepted request and compares them with the result channel
// depends on jsu_pkg
module json_string_unescape_utf8_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_ready,
    input  wire jsu_pkg::byte_t s_in_byte,
    input  wire logic           s_end_of_string,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wire jsu_pkg::byte_t m_out_byte,
    input  wire logic           m_run_last,
    input  wire logic           m_string_done,
    output int                  fail_count,
    output int                  outstanding
);

    typedef enum logic [1:0] {
        DEC_PLAIN,
        DEC_ESC,
        DEC_UHEX
    } dec_mode_t;

    typedef struct packed {
        jsu_pkg::byte_t value;
        logic           run_last;
        logic           string_done;
    } out_rec_t;

    localparam jsu_pkg::byte_t CH_BSLASH = "\\";
    localparam jsu_pkg::byte_t CH_QUOTE  = "\"";
    localparam jsu_pkg::byte_t CH_B      = "b";
    localparam jsu_pkg::byte_t CH_F      = "f";
    localparam jsu_pkg::byte_t CH_N      = "n";
    localparam jsu_pkg::byte_t CH_R      = "r";
    localparam jsu_pkg::byte_t CH_T      = "t";
    localparam jsu_pkg::byte_t CH_U      = "u";

    localparam jsu_pkg::byte_t CODE_BS  = 8'h08;
    localparam jsu_pkg::byte_t CODE_FF  = 8'h0C;
    localparam jsu_pkg::byte_t CODE_LF  = 8'h0A;
    localparam jsu_pkg::byte_t CODE_CR  = 8'h0D;
    localparam jsu_pkg::byte_t CODE_TAB = 8'h09;

    localparam logic [15:0]    U8_TWO_MIN   = 16'h0080;
    localparam logic [15:0]    U8_THREE_MIN = 16'h0800;
    localparam jsu_pkg::byte_t U8_LEAD2     = 8'hC0;
    localparam jsu_pkg::byte_t U8_LEAD3     = 8'hE0;
    localparam jsu_pkg::byte_t U8_CONT      = 8'h80;
    localparam jsu_pkg::byte_t U8_MASK      = 8'h3F;

    dec_mode_t   esc_state = DEC_PLAIN;
    logic [1:0]  u_count   = '0;
    logic [15:0] u_code    = '0;
    logic        u_stopped = 1'b0;

    jsu_pkg::byte_t decoded[$];
    out_rec_t       expected_bytes[$];
    int             errors = 0;

    function automatic bit hex_nibble(input jsu_pkg::byte_t c, output logic [3:0] v);
        v = '0;
        if (c >= "0" && c <= "9") begin
            v = c[3:0];
            return 1'b1;
        end
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void emit_utf8(input logic [15:0] u);
        if (u < U8_TWO_MIN) begin
            decoded.push_back(u[7:0]);
        end else if (u < U8_THREE_MIN) begin
            decoded.push_back(U8_LEAD2 | jsu_pkg::byte_t'(u >> 6));
            decoded.push_back(U8_CONT | (u[7:0] & U8_MASK));
        end else begin
            decoded.push_back(U8_LEAD3 | jsu_pkg::byte_t'(u >> 12));
            decoded.push_back(U8_CONT | (jsu_pkg::byte_t'(u >> 6) & U8_MASK));
            decoded.push_back(U8_CONT | (u[7:0] & U8_MASK));
        end
    endfunction

    task automatic predict_request(input jsu_pkg::byte_t c, input logic eos);
        logic [3:0] nib;
        decoded.delete();
        case (esc_state)
            DEC_ESC: begin
                esc_state = DEC_PLAIN;
                case (c)
                    CH_BSLASH, CH_QUOTE: decoded.push_back(c);
                    CH_B: decoded.push_back(CODE_BS);
                    CH_F: decoded.push_back(CODE_FF);
                    CH_N: decoded.push_back(CODE_LF);
                    CH_R: decoded.push_back(CODE_CR);
                    CH_T: decoded.push_back(CODE_TAB);
                    CH_U: begin
                        esc_state = DEC_UHEX;
                        u_count = '0;
                        u_code = '0;
                        u_stopped = 1'b0;
                        if (eos) emit_utf8(16'h0000);
                    end
                    default: begin
                        decoded.push_back(CH_BSLASH);
                        decoded.push_back(c);
                    end
                endcase
            end
            DEC_UHEX: begin
                if (!u_stopped && hex_nibble(c, nib)) u_code = {u_code[11:0], nib};
                else u_stopped = 1'b1;
                if (u_count == 2'd3 || eos) begin
                    emit_utf8(u_code);
                    esc_state = DEC_PLAIN;
                    u_count = '0;
                    u_code = '0;
                    u_stopped = 1'b0;
                end else begin
                    u_count = u_count + 2'd1;
                end
            end
            default: begin
                if (c == CH_BSLASH) begin
                    if (eos) decoded.push_back(CH_BSLASH);
                    else esc_state = DEC_ESC;
                end else begin
                    esc_state = DEC_PLAIN;
                    decoded.push_back(c);
                end
            end
        endcase
        foreach (decoded[i]) begin
            expected_bytes.push_back('{decoded[i], i == decoded.size() - 1,
                                       eos && (i == decoded.size() - 1)});
        end
        if (eos) begin
            esc_state = DEC_PLAIN;
            u_count = '0;
            u_code = '0;
            u_stopped = 1'b0;
        end
    endtask

    task automatic check_result();
        out_rec_t want;
        if (expected_bytes.size() == 0) begin
            $error("out_byte %02h arrived with no result expected", m_out_byte);
            errors++;
        end else begin
            want = expected_bytes.pop_front();
            if (m_out_byte !== want.value) begin
                $error("out_byte expected %02h actual %02h", want.value, m_out_byte);
                errors++;
            end
            if (m_run_last !== want.run_last) begin
                $error("run_last expected %0b actual %0b", want.run_last, m_run_last);
                errors++;
            end
            if (m_string_done !== want.string_done) begin
                $error("string_done expected %0b actual %0b", want.string_done,
                       m_string_done);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_request(s_in_byte, s_end_of_string);
            if (m_valid && m_ready) check_result();
        end
        fail_count <= errors;
        outstanding <= expected_bytes.size();
    end

endmodule

[verif/json_string_unescape_utf8_top_tb.sv]
`timescale 1ns / 1ps
// testbench top for the json string unescaper: clock, reset, escaped strings
// with random gaps on both channels, watchdog and verdict
// depends on jsu_pkg, json_string_unescape_utf8_top, json_string_unescape_utf8_checker
module json_string_unescape_utf8_top_tb;

    localparam int ITEM_TARGET    = 500;
    localparam int GAP_MAX        = 17;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int STALL_AT       = 150;
    localparam int BURST_ITEMS    = 60;
    localparam int PAUSE_AT       = 320;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    localparam jsu_pkg::byte_t CH_BSLASH = "\\";
    localparam jsu_pkg::byte_t CH_U      = "u";
    localparam logic [6:0][7:0] ESC_CHARS = {"\\", "\"", "b", "f", "n", "r", "t"};

    logic           aclk            = 1'b0;
    logic           aresetn         = 1'b0;
    logic           s_valid         = 1'b0;
    logic           s_ready;
    jsu_pkg::byte_t s_in_byte       = '0;
    logic           s_end_of_string = 1'b0;
    logic           m_valid;
    logic           m_ready         = 1'b0;
    jsu_pkg::byte_t m_out_byte;
    logic           m_run_last;
    logic           m_string_done;

    int             fail_count;
    int             outstanding;
    int             sent         = 0;
    int             burst_left   = 0;
    int             tx_quiet     = 0;
    int             stall_asks   = 0;
    int             stuck_cycles = 0;
    jsu_pkg::byte_t str_q[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    json_string_unescape_utf8_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_string(s_end_of_string),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_run_last     (m_run_last),
        .m_string_done  (m_string_done)
    );

    json_string_unescape_utf8_checker u_unescape_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_string(s_end_of_string),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_run_last     (m_run_last),
        .m_string_done  (m_string_done),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) quiet = $urandom_range(10, 40);
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic jsu_pkg::byte_t hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + jsu_pkg::byte_t'(n);
        return ($urandom_range(0, 1) ? "a" : "A") + jsu_pkg::byte_t'(n) - 8'd10;
    endfunction

    function automatic jsu_pkg::byte_t noisy_char();
        return $urandom_range(0, 1) ? hex_char(4'($urandom_range(0, 15)))
                                    : jsu_pkg::byte_t'($urandom);
    endfunction

    // random string of plain bytes, escapes and \u sequences, some cut short at the end
    function automatic void build_string();
        int             tokens;
        int             kind;
        int             n;
        logic [15:0]    code;
        jsu_pkg::byte_t b;
        str_q.delete();
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                do b = jsu_pkg::byte_t'($urandom); while (b == CH_BSLASH);
                str_q.push_back(b);
            end else if (kind < 60) begin
                str_q.push_back(CH_BSLASH);
                str_q.push_back(ESC_CHARS[3'($urandom_range(0, 6))]);
            end else if (kind < 68) begin
                str_q.push_back(CH_BSLASH);
                str_q.push_back(jsu_pkg::byte_t'($urandom));
            end else if (kind < 90) begin
                case ($urandom_range(0, 2))
                    0: code = 16'($urandom_range(16'h0000, 16'h007F));
                    1: code = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                str_q.push_back(CH_BSLASH);
                str_q.push_back(CH_U);
                for (int h = 3; h >= 0; h--) str_q.push_back(hex_char(code[h*4 +: 4]));
            end else if (kind < 96) begin
                str_q.push_back(CH_BSLASH);
                str_q.push_back(CH_U);
                repeat (4) str_q.push_back(noisy_char());
            end else begin
                str_q.push_back(CH_BSLASH);
                if ($urandom_range(0, 3) != 0) begin
                    str_q.push_back(CH_U);
                    n = $urandom_range(0, 3);
                    repeat (n) str_q.push_back(noisy_char());
                end
                break;
            end
        end
    endfunction

    task automatic send_req(input jsu_pkg::byte_t b, input logic eos);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = draw_gap(tx_quiet);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic send_string();
        foreach (str_q[i]) send_req(str_q[i], i == str_q.size() - 1);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin : rx_side
        int gap;
        int served;
        int quiet;
        served = 0;
        quiet = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (served != stall_asks) begin
                served++;
                gap = RX_HOLD_CYCLES;
            end else begin
                gap = draw_gap(quiet);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : tx_side
        bit stall_asked;
        bit paused;
        stall_asked = 1'b0;
        paused = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain zero byte, every known escape, unknown escape, two-byte \u
        str_q = {8'h00, "\\", "b", "\\", "f", "\\", "n", "\\", "r", "\\", "t",
                 "\\", "\\", "\\", "\"", "\\", 8'hFF, "\\", "u", "0", "7", "F", "f"};
        send_string();
        // lone backslash at end
        str_q = {"\\"};
        send_string();
        // bare u at end
        str_q = {"\\", "u"};
        send_string();
        // partial \u cut by a non-hex char and the end of the string
        str_q = {"\\", "u", "7", "G"};
        send_string();

        while (sent < ITEM_TARGET) begin
            if (!stall_asked && sent >= STALL_AT) begin
                stall_asked = 1'b1;
                stall_asks++;
                burst_left = BURST_ITEMS;
            end
            if (!paused && sent >= PAUSE_AT) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                wait_drained();
            end
            build_string();
            send_string();
        end
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/jsu_pkg.sv
src/jsu_decode.sv
src/jsu_emit.sv
src/json_string_unescape_utf8_top.sv
verif/json_string_unescape_utf8_checker.sv
verif/json_string_unescape_utf8_top_tb.sv
